// ===== rtl/core/mpv_pkg.sv =====
// ----------------------------------------------------------------------------
// Merkle path verifier package
// Shared types, SHA-256 constants and round functions.
// ----------------------------------------------------------------------------
package mpv_pkg;

    localparam int INDEX_BITS = 32;
    localparam int POS_W      = (INDEX_BITS < 32) ? INDEX_BITS : 32;
    localparam int ROUNDS     = 64;
    localparam int RND_W      = 6;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_LOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROOT_HIGH = 1'b1;

    localparam logic OP_LEAF    = 1'b0;
    localparam logic OP_SIBLING = 1'b1;

    localparam logic [31:0] PAD_WORD = 32'h8000_0000;
    localparam logic [31:0] LEN_WORD = 32'd256;

    typedef struct packed {
        logic        op;
        logic [63:0] word_low;
        logic [63:0] word_high;
        logic [31:0] leaf_index;
        logic        last;
    } in_item_t;

    typedef struct packed {
        logic        matches_res;
        logic [63:0] computed_low;
        logic [63:0] computed_high;
    } out_item_t;

    typedef struct packed {
        logic load_leaf;
        logic start_hash;
        logic round_step;
        logic finish_hash;
        logic capture_out;
    } dp_cmd_t;

    typedef struct packed {
        logic last_round;
    } dp_sts_t;

    localparam logic [31:0] K_TAB [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] IV_TAB [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] bswap32(input logic [31:0] x);
        bswap32 = {x[7:0], x[15:8], x[23:16], x[31:24]};
    endfunction

    function automatic logic [63:0] digest_word(input logic [31:0] h0, input logic [31:0] h1);
        digest_word = {bswap32(h1), bswap32(h0)};
    endfunction

endpackage

// ===== rtl/core/mpv_ctrl.sv =====
// ----------------------------------------------------------------------------
// Merkle path verifier controller
// Sequences leaf loads, the 64 compression rounds and result delivery.
// ----------------------------------------------------------------------------
module mpv_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_op,
    input  logic             in_last,
    output logic             out_valid,
    input  logic             out_ready,
    output mpv_pkg::dp_cmd_t cmd,
    input  mpv_pkg::dp_sts_t sts
);
    import mpv_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ROUND = 4'b0010,
        ST_FIN   = 4'b0100,
        ST_OUT   = 4'b1000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;
    logic   out_full_reg, out_full_next;
    logic   out_free;
    logic   accept;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_full_reg;
    assign out_free  = !out_full_reg || out_ready;
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        state_next      = state_reg;
        last_next       = last_reg;
        cmd             = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    last_next = in_last;
                    if (in_op == OP_LEAF)
                    begin
                        cmd.load_leaf = 1'b1;
                        if (in_last)
                        begin
                            if (out_free)
                                cmd.capture_out = 1'b1;
                            else
                                state_next = ST_OUT;
                        end
                    end
                    else
                    begin
                        cmd.start_hash = 1'b1;
                        state_next     = ST_ROUND;
                    end
                end
            end
            ST_ROUND:
            begin
                cmd.round_step = 1'b1;
                if (sts.last_round)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                cmd.finish_hash = 1'b1;
                if (last_reg && !out_free)
                    state_next = ST_OUT;
                else
                begin
                    cmd.capture_out = last_reg;
                    state_next      = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    cmd.capture_out = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (cmd.capture_out)
            out_full_next = 1'b1;
        else if (out_ready)
            out_full_next = 1'b0;
        else
            out_full_next = out_full_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            last_reg     <= 1'b0;
            out_full_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            last_reg     <= last_next;
            out_full_reg <= out_full_next;
        end
    end

    a_onehot: assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ROUND) |-> !in_ready)
        else $error("accept while hashing");
    a_fin_after_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FIN) |-> $past(state_reg == ST_ROUND))
        else $error("finish without rounds");

endmodule

// ===== rtl/core/mpv_dp.sv =====
// ----------------------------------------------------------------------------
// Merkle path verifier datapath
// Node and position registers, message schedule window and SHA-256 round.
// ----------------------------------------------------------------------------
module mpv_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  mpv_pkg::dp_cmd_t                  cmd,
    output mpv_pkg::dp_sts_t                  sts,
    input  mpv_pkg::in_item_t                 in_item,
    input  logic                              cfg_we,
    input  logic [mpv_pkg::CFG_IDX_W-1:0]     cfg_idx,
    input  logic [mpv_pkg::CFG_DATA_W-1:0]    cfg_data,
    output mpv_pkg::out_item_t                out_item
);
    import mpv_pkg::*;

    logic [63:0]       node_lo_reg, node_lo_next, node_hi_reg, node_hi_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [63:0]       root_lo_reg, root_hi_reg;
    logic [RND_W-1:0]  rnd_reg, rnd_next;
    logic [31:0]       s_reg [8];
    logic [31:0]       s_next [8];
    logic [31:0]       w_reg [16];
    logic [31:0]       w_next [16];
    logic [31:0]       msg [16];
    logic [63:0]       left_lo, left_hi, right_lo, right_hi;
    logic [31:0]       wi, a15, b2, sg0, sg1, t1, t2;
    logic [31:0]       h [4];
    out_item_t         res_reg, res_next;

    always_comb
    begin
        if (!pos_reg[0])
        begin
            left_lo = node_lo_reg; left_hi = node_hi_reg;
            right_lo = in_item.word_low; right_hi = in_item.word_high;
        end
        else
        begin
            left_lo = in_item.word_low; left_hi = in_item.word_high;
            right_lo = node_lo_reg; right_hi = node_hi_reg;
        end
        msg[0] = bswap32(left_lo[31:0]);
        msg[1] = bswap32(left_lo[63:32]);
        msg[2] = bswap32(left_hi[31:0]);
        msg[3] = bswap32(left_hi[63:32]);
        msg[4] = bswap32(right_lo[31:0]);
        msg[5] = bswap32(right_lo[63:32]);
        msg[6] = bswap32(right_hi[31:0]);
        msg[7] = bswap32(right_hi[63:32]);
        msg[8] = PAD_WORD;
        for (int i = 9; i < 15; i++)
            msg[i] = '0;
        msg[15] = LEN_WORD;
    end

    // window holds w[i..i+15] with w_reg[0] the current word
    always_comb
    begin
        wi  = w_reg[0];
        a15 = w_reg[1];
        b2  = w_reg[14];
        sg0 = rotr(a15, 7) ^ rotr(a15, 18) ^ (a15 >> 3);
        sg1 = rotr(b2, 17) ^ rotr(b2, 19) ^ (b2 >> 10);
        t1  = s_reg[7] + (rotr(s_reg[4], 6) ^ rotr(s_reg[4], 11) ^ rotr(s_reg[4], 25))
            + ((s_reg[4] & s_reg[5]) ^ (~s_reg[4] & s_reg[6])) + K_TAB[rnd_reg] + wi;
        t2  = (rotr(s_reg[0], 2) ^ rotr(s_reg[0], 13) ^ rotr(s_reg[0], 22))
            + ((s_reg[0] & s_reg[1]) ^ (s_reg[0] & s_reg[2]) ^ (s_reg[1] & s_reg[2]));
        for (int i = 0; i < 4; i++)
            h[i] = IV_TAB[i] + s_reg[i];
    end

    always_comb
    begin
        node_lo_next = node_lo_reg;
        node_hi_next = node_hi_reg;
        pos_next     = pos_reg;
        rnd_next     = rnd_reg;
        s_next       = s_reg;
        w_next       = w_reg;
        if (cmd.load_leaf)
        begin
            node_lo_next = in_item.word_low;
            node_hi_next = in_item.word_high;
            pos_next     = in_item.leaf_index[POS_W-1:0];
        end
        if (cmd.start_hash)
        begin
            s_next   = IV_TAB;
            w_next   = msg;
            rnd_next = '0;
        end
        if (cmd.round_step)
        begin
            s_next[7] = s_reg[6]; s_next[6] = s_reg[5]; s_next[5] = s_reg[4];
            s_next[4] = s_reg[3] + t1;
            s_next[3] = s_reg[2]; s_next[2] = s_reg[1]; s_next[1] = s_reg[0];
            s_next[0] = t1 + t2;
            for (int i = 0; i < 15; i++)
                w_next[i] = w_reg[i+1];
            w_next[15] = w_reg[0] + sg0 + w_reg[9] + sg1;
            rnd_next   = rnd_reg + 1'b1;
        end
        if (cmd.finish_hash)
        begin
            node_lo_next = digest_word(h[0], h[1]);
            node_hi_next = digest_word(h[2], h[3]);
            pos_next     = pos_reg >> 1;
        end
    end

    always_comb
    begin
        res_next = res_reg;
        if (cmd.capture_out)
        begin
            res_next.matches_res   = (node_lo_next == root_lo_reg)
                                     && (node_hi_next == root_hi_reg);
            res_next.computed_low  = node_lo_next;
            res_next.computed_high = node_hi_next;
        end
    end

    assign sts.last_round = (rnd_reg == RND_W'(ROUNDS - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_lo_reg <= '0;
            node_hi_reg <= '0;
            pos_reg     <= '0;
            root_lo_reg <= '0;
            root_hi_reg <= '0;
            rnd_reg     <= '0;
            res_reg     <= '0;
        end
        else
        begin
            node_lo_reg <= node_lo_next;
            node_hi_reg <= node_hi_next;
            pos_reg     <= pos_next;
            rnd_reg     <= rnd_next;
            res_reg     <= res_next;
            if (cfg_we && cfg_idx == CFG_ROOT_LOW)
                root_lo_reg <= cfg_data;
            if (cfg_we && cfg_idx == CFG_ROOT_HIGH)
                root_hi_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg <= s_next;
        w_reg <= w_next;
    end

    assign out_item = res_reg;

    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({cmd.load_leaf, cmd.start_hash, cmd.round_step, cmd.finish_hash}))
        else $error("conflicting commands");
    a_pos_shift: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish_hash |=> pos_reg == ($past(pos_reg) >> 1))
        else $error("position not shifted");
    a_rnd_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start_hash |=> rnd_reg == '0)
        else $error("round counter not cleared");

endmodule

// ===== rtl/core/merkle_path_verify_sha256_top.sv =====
// ----------------------------------------------------------------------------
// Merkle path verifier, SHA-256 truncated to 128 bits
// Top level: controller plus datapath.
// ----------------------------------------------------------------------------
// Usage:
//   Write the expected root through cfg_we/cfg_idx/cfg_data while idle
//   (index 0 low word, index 1 high word).
//   Send a leaf item (op 0) then one sibling item (op 1) per tree level;
//   the item with last set produces one result item on the output channel.
//   A sibling item is processed in steps: one load of the message window,
//   64 rounds of the single shared round unit, one digest fold. One item
//   is processed at a time.
//   The result is captured in the output register when a leaf with last is
//   taken, or at the digest fold of a sibling with last, if the register is free.
//   The result sits in the output register until out_ready while new items
//   keep flowing; only a further result waits for the register to free,
//   and no item is taken during that wait.
//   Reset clears node, position, root, output register and control.
// ----------------------------------------------------------------------------
module merkle_path_verify_sha256_top (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mpv_pkg::in_item_t              in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mpv_pkg::out_item_t             out_data,
    input  logic                           cfg_we,
    input  logic [mpv_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [mpv_pkg::CFG_DATA_W-1:0] cfg_data
);
    import mpv_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    mpv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_op     (in_data.op),
        .in_last   (in_data.last),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    mpv_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_item  (in_data),
        .cfg_we   (cfg_we),
        .cfg_idx  (cfg_idx),
        .cfg_data (cfg_data),
        .out_item (out_data)
    );

endmodule

// ===== verif/tb_merkle_path_verify_sha256_top.sv =====
// ----------------------------------------------------------------------------
// Merkle path verifier testbench
// Drives leaf and sibling items through the valid/ready input channel and
// predicts each result with a local SHA-256 path model. Every result item is
// checked field by field against the oldest prediction. Random idling is
// applied on both sides, and one long output stall makes the input back up.
// The expected root is rewritten between phases.
// ----------------------------------------------------------------------------
module tb_merkle_path_verify_sha256_top;

    import mpv_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    out_item_t   root_expect_q[$];
    int          error_count;
    int          item_count;
    int          result_count;
    int          match_count;
    bit          idle_on;
    bit          hold_req;
    int          hold_left;

    logic [63:0] node_lo;
    logic [63:0] node_hi;
    logic [31:0] pos_bits;
    logic [63:0] root_lo;
    logic [63:0] root_hi;

    localparam logic [31:0] RK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H0 [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    merkle_path_verify_sha256_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic logic [31:0] ror32(logic [31:0] x, int n);
        ror32 = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [127:0] node_digest(logic [63:0] l0, logic [63:0] l1,
                                                 logic [63:0] r0, logic [63:0] r1);
        logic [63:0]  words [4];
        logic [31:0]  w [16];
        logic [31:0]  s [8];
        logic [31:0]  part, wi, t1, t2, a, b, s0, s1, hw;
        logic [63:0]  v [2];
        logic [63:0]  dword;
        int           k;
        words[0] = l0; words[1] = l1; words[2] = r0; words[3] = r1;
        for (int i = 0; i < 8; i++)
        begin
            dword = words[i >> 1] >> (32 * (i & 1));
            part  = dword[31:0];
            w[i]  = {part[7:0], part[15:8], part[23:16], part[31:24]};
        end
        w[8] = 32'h8000_0000;
        for (int i = 9; i < 15; i++)
            w[i] = '0;
        w[15] = 32'd256;
        for (int i = 0; i < 8; i++)
            s[i] = H0[i];
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
                wi = w[i];
            else
            begin
                a  = w[(i - 15) & 15];
                b  = w[(i - 2) & 15];
                s0 = ror32(a, 7) ^ ror32(a, 18) ^ (a >> 3);
                s1 = ror32(b, 17) ^ ror32(b, 19) ^ (b >> 10);
                wi = w[i & 15] + s0 + w[(i - 7) & 15] + s1;
                w[i & 15] = wi;
            end
            t1 = s[7] + (ror32(s[4], 6) ^ ror32(s[4], 11) ^ ror32(s[4], 25))
                 + ((s[4] & s[5]) ^ (~s[4] & s[6])) + RK[i] + wi;
            t2 = (ror32(s[0], 2) ^ ror32(s[0], 13) ^ ror32(s[0], 22))
                 + ((s[0] & s[1]) ^ (s[0] & s[2]) ^ (s[1] & s[2]));
            s[7] = s[6]; s[6] = s[5]; s[5] = s[4]; s[4] = s[3] + t1;
            s[3] = s[2]; s[2] = s[1]; s[1] = s[0]; s[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
            s[i] = s[i] + H0[i];
        for (int i = 0; i < 2; i++)
        begin
            v[i] = '0;
            for (int j = 0; j < 8; j++)
            begin
                k  = i * 8 + j;
                hw = s[k >> 2] >> (24 - 8 * (k & 3));
                v[i][8*j +: 8] = hw[7:0];
            end
        end
        node_digest = {v[1], v[0]};
    endfunction

    task automatic predict_path_step(input in_item_t it);
        logic [127:0] h;
        out_item_t    r;
        if (it.op == OP_LEAF)
        begin
            node_lo  = it.word_low;
            node_hi  = it.word_high;
            pos_bits = it.leaf_index;
        end
        else
        begin
            if (pos_bits[0] == 1'b0)
                h = node_digest(node_lo, node_hi, it.word_low, it.word_high);
            else
                h = node_digest(it.word_low, it.word_high, node_lo, node_hi);
            node_lo  = h[63:0];
            node_hi  = h[127:64];
            pos_bits = pos_bits >> 1;
        end
        if (it.last)
        begin
            r.matches_res   = (node_lo == root_lo) && (node_hi == root_hi);
            r.computed_low  = node_lo;
            r.computed_high = node_hi;
            root_expect_q   = {root_expect_q, r};
        end
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("tb: mismatch %s got %h want %h", what, got, want);
        error_count++;
    endtask

    task automatic send_item(input in_item_t it);
        bit ok;
        while (idle_on && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        ok = 1'b0;
        while (!ok)
        begin
            @(negedge clk);
            ok = in_ready;
            @(posedge clk);
        end
        predict_path_step(it);
        item_count++;
    endtask

    task automatic end_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (root_expect_q.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic write_root(input logic [63:0] lo, input logic [63:0] hi);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ROOT_LOW;
        cfg_data <= lo;
        @(posedge clk);
        cfg_idx  <= CFG_ROOT_HIGH;
        cfg_data <= hi;
        @(posedge clk);
        cfg_we   <= 1'b0;
        root_lo  = lo;
        root_hi  = hi;
    endtask

    function automatic in_item_t make_item(logic op, logic [63:0] lo, logic [63:0] hi,
                                           logic [31:0] idx, logic last);
        in_item_t it;
        it.op = op; it.word_low = lo; it.word_high = hi;
        it.leaf_index = idx; it.last = last;
        return it;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_directed();
        logic [127:0] h;
        send_item(make_item(OP_SIBLING, 64'h0, 64'h0, 32'h0, 1'b1));
        send_item(make_item(OP_LEAF, 64'h0, 64'h0, 32'h0, 1'b1));
        send_item(make_item(OP_LEAF, '1, '1, '1, 1'b1));
        send_item(make_item(OP_LEAF, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                            32'h0, 1'b0));
        send_item(make_item(OP_SIBLING, '1, 64'h0, '1, 1'b0));
        send_item(make_item(OP_SIBLING, 64'h0, '1, 32'h0, 1'b1));
        send_item(make_item(OP_LEAF, '1, 64'h0, '1, 1'b0));
        send_item(make_item(OP_SIBLING, 64'h0, '1, 32'h0, 1'b1));
        send_item(make_item(OP_SIBLING, '1, '1, 32'h0, 1'b1));
        send_item(make_item(OP_LEAF, 64'h5, 64'h6, 32'h1, 1'b0));
        send_item(make_item(OP_LEAF, 64'h7, 64'h8, 32'h1, 1'b0));
        for (int i = 0; i < 3; i++)
            send_item(make_item(OP_SIBLING, rand64(), rand64(), 32'h0, i == 2));
        end_sending();
        drain();
        h = node_digest(64'h11, 64'h22, 64'h33, 64'h44);
        write_root(h[63:0], h[127:64]);
        send_item(make_item(OP_LEAF, 64'h11, 64'h22, 32'h0, 1'b0));
        send_item(make_item(OP_SIBLING, 64'h33, 64'h44, 32'h0, 1'b1));
        h = node_digest(64'h33, 64'h44, 64'h11, 64'h22);
        send_item(make_item(OP_LEAF, 64'h33, 64'h44, 32'h0, 1'b0));
        send_item(make_item(OP_SIBLING, 64'h11, 64'h22, 32'h1, 1'b1));
        send_item(make_item(OP_LEAF, h[63:0], h[127:64], 32'h0, 1'b1));
        end_sending();
        drain();
        write_root('1, '1);
        send_item(make_item(OP_LEAF, '1, '1, 32'h8000_0000, 1'b1));
        end_sending();
        drain();
    endtask

    task automatic test_random(input int n_items);
        int       sent;
        int       depth;
        int       next_cfg;
        in_item_t it;
        logic [31:0] idx;
        sent     = 0;
        next_cfg = 300;
        while (sent < n_items)
        begin
            idle_on = !(sent > n_items / 3 && sent < n_items / 2);
            if (sent >= next_cfg)
            begin
                next_cfg += 300;
                end_sending();
                drain();
                if ($urandom_range(0, 1))
                    write_root(node_lo, node_hi);
                else
                    write_root(rand64(), rand64());
            end
            if ($urandom_range(0, 99) < 85)
            begin
                depth = $urandom_range(0, 9);
                case ($urandom_range(0, 3))
                    0: idx = '0;
                    1: idx = '1;
                    default: idx = $urandom;
                endcase
                if (depth == 0 && $urandom_range(0, 1))
                    send_item(make_item(OP_LEAF, root_lo, root_hi, idx, 1'b1));
                else
                    send_item(make_item(OP_LEAF, rand64(), rand64(), idx, depth == 0));
                for (int i = 1; i <= depth; i++)
                    send_item(make_item(OP_SIBLING, rand64(), rand64(), $urandom,
                                        i == depth));
                sent += depth + 1;
            end
            else
            begin
                it = make_item(1'($urandom_range(0, 1)), rand64(), rand64(), $urandom,
                               1'($urandom_range(0, 1)));
                send_item(it);
                sent++;
            end
        end
        idle_on = 1'b1;
        end_sending();
        drain();
    endtask

    task automatic test_output_stall();
        idle_on  = 1'b0;
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++)
            send_item(make_item(i % 2 ? OP_SIBLING : OP_LEAF, rand64(), rand64(),
                                $urandom, 1'b1));
        idle_on = 1'b1;
        end_sending();
        drain();
    endtask

    always @(posedge clk)
    begin
        if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 500;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(idle_on && $urandom_range(0, 99) < 19);
    end

    always @(negedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (root_expect_q.size() == 0)
                report_mismatch("unexpected result", out_data.computed_low, 64'h0);
            else
            begin
                want = root_expect_q.pop_front();
                result_count++;
                if (out_data.matches_res)
                    match_count++;
                if (out_data.matches_res !== want.matches_res)
                    report_mismatch("matches_res", 64'(out_data.matches_res),
                                    64'(want.matches_res));
                if (out_data.computed_low !== want.computed_low)
                    report_mismatch("computed_low", out_data.computed_low,
                                    want.computed_low);
                if (out_data.computed_high !== want.computed_high)
                    report_mismatch("computed_high", out_data.computed_high,
                                    want.computed_high);
            end
        end
    end

    initial
    begin
        #10_000_000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        clk       = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        out_ready = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_ROOT_LOW;
        cfg_data  = '0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        hold_left = 0;
        node_lo   = '0;
        node_hi   = '0;
        pos_bits  = '0;
        root_lo   = '0;
        root_hi   = '0;
        error_count  = 0;
        item_count   = 0;
        result_count = 0;
        match_count  = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_output_stall();
        test_random(1500);
        if (root_expect_q.size() != 0)
            report_mismatch("results left over", 64'(root_expect_q.size()), 64'h0);
        $display("tb: %0d items sent, %0d roots checked, %0d matched the root",
                 item_count, result_count, match_count);
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
